// ===== hw/rtl/ps2md_pkg.sv =====
// shared types and codes for the ps/2 mouse packet event decoder
// no dependencies; imported by every module of the block
package ps2md_pkg;

	// event kinds carried on the result stream
	localparam logic [1:0] KIND_PRESS   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_REL_X   = 2'd2;
	localparam logic [1:0] KIND_REL_Y   = 2'd3;

	// packet_mode register codes
	localparam logic [1:0] MODE_BASIC    = 2'd0;
	localparam logic [1:0] MODE_SCROLL   = 2'd1;
	localparam logic [1:0] MODE_NONE     = 2'd2;
	// no meaning, decoded like MODE_NONE
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	// register index of packet_mode
	localparam logic REG_PACKET_MODE = 1'b0;

	// byte 0 always has this bit set in a well-formed packet
	localparam int SYNC_BIT = 3;

	localparam int NUM_BUTTONS = 3;
	localparam int NUM_EVENTS  = 5;

	// event mask bit positions: buttons 0..2, then x, then y
	localparam int EV_X = 3;
	localparam int EV_Y = 4;

	// events of one completed packet, handed from the assembler to the emitter
	typedef struct packed {
		logic [NUM_EVENTS-1:0]  mask;
		logic [NUM_BUTTONS-1:0] buttons;
		logic signed [7:0]      rel_x;
		logic signed [7:0]      rel_y;
	} evset_t;

endpackage

// ===== hw/rtl/ps2_mouse_packet_event_decoder.sv =====
// top level of the ps/2 mouse packet event decoder
// depends on ps2md_pkg, ps2md_assembler and ps2md_emitter
//
// usage
// - slave stream s_*: one received mouse byte per transaction in s_tdata[7:0]
// - master stream m_*: one event per transaction; kind in m_tuser, button index
//   and signed motion in m_tdata, m_tlast marks the last event of an input byte
// - apb port: packet_mode at byte address 0 (0 basic 3-byte, 1 scrolling
//   4-byte, 2 or 3 discard every byte); write it only while the block is idle
// - a byte is folded into the packet state in the cycle it is accepted; a byte
//   that completes a packet with changes loads the event register, and each
//   event passes from there to the output register before it shows on m_tvalid
// - throughput: one byte per cycle while no events are pending; a packet with up
//   to five events holds the event register until all have moved on, one event
//   per cycle while the receiver takes them, and s_tready rises again in the
//   cycle the last event moves to the output register
// - when the receiver stalls, the output register holds its event and the event
//   register waits; s_tready stays low until the pending events drain
// - reset clears byte position, stored buttons, mode and all valid flags
module ps2_mouse_packet_event_decoder
	import ps2md_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [1:0] button_index, [9:2] motion_value, rest zero
	output logic [1:0]  m_tuser,   // [1:0] event_kind
	output logic        m_tlast,   // last_of_run
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [1:0]        mode_q;
	logic              s_accept;
	logic              has_events;
	evset_t            evset;
	logic              emit_free;
	logic [1:0]        ev_index;
	logic signed [7:0] ev_motion;

	// config register, word address taken from paddr[2]
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BASIC;
		end else if (psel && penable && pwrite && (paddr[2] == REG_PACKET_MODE)) begin
			mode_q <= pwdata[1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_PACKET_MODE) begin
			prdata = {30'd0, mode_q};
		end
	end

	// input transaction, taken whenever the event register is or becomes free
	assign s_tready = emit_free;
	assign s_accept = s_tvalid && s_tready;

	ps2md_assembler u_assembler (
		.clk         (clk),
		.arst_n      (arst_n),
		.packet_mode (mode_q),
		.accept      (s_accept),
		.rx_byte     (s_tdata),
		.has_events  (has_events),
		.evset       (evset)
	);

	ps2md_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (has_events),
		.evset      (evset),
		.free       (emit_free),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (m_tuser),
		.out_index  (ev_index),
		.out_motion (ev_motion),
		.out_last   (m_tlast)
	);

	assign m_tdata = {6'd0, ev_motion, ev_index};

endmodule

// ===== hw/rtl/ps2md_assembler.sv =====
// packet assembly: byte position, stored packet bytes and button state
// depends on ps2md_pkg
module ps2md_assembler
	import ps2md_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] packet_mode,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	output logic       has_events,
	output evset_t     evset
);

	logic [1:0]             pos_q;
	logic [NUM_BUTTONS-1:0] byte0_q;
	logic [7:0]             byte1_q;
	logic [7:0]             byte2_q;
	logic [NUM_BUTTONS-1:0] prev_btn_q;

	logic                   enabled;
	logic                   need4;
	logic                   drop_sync;
	logic                   take;
	logic [2:0]             next_pos;
	logic                   complete;
	logic [NUM_BUTTONS-1:0] b0;
	logic [7:0]             b1;
	logic [7:0]             b2;

	always_comb begin
		enabled   = (packet_mode == MODE_BASIC) || (packet_mode == MODE_SCROLL);
		need4     = (packet_mode == MODE_SCROLL);
		drop_sync = (pos_q == 2'd0) && !rx_byte[SYNC_BIT];
		take      = accept && enabled && !drop_sync;
		next_pos  = {1'b0, pos_q} + 3'd1;
		complete  = need4 ? (next_pos >= 3'd4) : (next_pos >= 3'd3);
		// byte 0 and 1 are always stored before a packet can complete
		b0 = byte0_q;
		b1 = byte1_q;
		b2 = (pos_q == 2'd2) ? rx_byte : byte2_q;

		evset.buttons  = b0;
		evset.rel_x    = b1;
		evset.rel_y    = b2;
		evset.mask     = {b2 != 8'd0, b1 != 8'd0, b0 ^ prev_btn_q};
		has_events     = take && complete && (evset.mask != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= 2'd0;
			prev_btn_q <= '0;
		end else if (take) begin
			if (complete) begin
				pos_q      <= 2'd0;
				prev_btn_q <= b0;
			end else begin
				pos_q <= next_pos[1:0];
			end
		end
	end

	// packet bytes need no reset; only the button bits of byte 0 are kept,
	// and the scroll byte is never used
	always_ff @(posedge clk) begin
		if (take) begin
			case (pos_q)
				2'd0:    byte0_q <= rx_byte[NUM_BUTTONS-1:0];
				2'd1:    byte1_q <= rx_byte;
				2'd2:    byte2_q <= rx_byte;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/ps2md_emitter.sv =====
// event emitter: holds one packet's events and sends them one per cycle while the receiver takes them
// depends on ps2md_pkg
module ps2md_emitter
	import ps2md_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  evset_t            evset,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_kind,
	output logic [1:0]        out_index,
	output logic signed [7:0] out_motion,
	output logic              out_last
);

	logic                   ev_valid_s1;
	logic [NUM_EVENTS-1:0]  ev_mask_s1;
	logic [NUM_BUTTONS-1:0] ev_btn_s1;
	logic signed [7:0]      ev_x_s1;
	logic signed [7:0]      ev_y_s1;

	logic                   out_valid_q;
	logic [1:0]             out_kind_q;
	logic [1:0]             out_index_q;
	logic signed [7:0]      out_motion_q;
	logic                   out_last_q;

	logic                   out_room;
	logic                   pop;
	logic [NUM_EVENTS-1:0]  pick;
	logic [NUM_EVENTS-1:0]  remain;
	logic [1:0]             sel_kind;
	logic [1:0]             sel_index;
	logic signed [7:0]      sel_motion;

	always_comb begin
		out_room = !out_valid_q || out_ready;
		pop      = ev_valid_s1 && out_room;
		// lowest pending event first
		pick     = ev_mask_s1 & (~ev_mask_s1 + NUM_EVENTS'(1));
		remain   = ev_mask_s1 & ~pick;
		free     = !ev_valid_s1 || (pop && (remain == '0));

		sel_kind   = KIND_REL_Y;
		sel_index  = 2'd0;
		sel_motion = ev_y_s1;
		case (pick)
			5'b00001: begin
				sel_kind   = ev_btn_s1[0] ? KIND_PRESS : KIND_RELEASE;
				sel_index  = 2'd0;
				sel_motion = 8'sd0;
			end
			5'b00010: begin
				sel_kind   = ev_btn_s1[1] ? KIND_PRESS : KIND_RELEASE;
				sel_index  = 2'd1;
				sel_motion = 8'sd0;
			end
			5'b00100: begin
				sel_kind   = ev_btn_s1[2] ? KIND_PRESS : KIND_RELEASE;
				sel_index  = 2'd2;
				sel_motion = 8'sd0;
			end
			5'b01000: begin
				sel_kind   = KIND_REL_X;
				sel_motion = ev_x_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				ev_valid_s1 <= 1'b1;
			end else if (pop && (remain == '0)) begin
				ev_valid_s1 <= 1'b0;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ev_mask_s1 <= evset.mask;
			ev_btn_s1  <= evset.buttons;
			ev_x_s1    <= evset.rel_x;
			ev_y_s1    <= evset.rel_y;
		end else if (pop) begin
			ev_mask_s1 <= remain;
		end
		if (pop) begin
			out_kind_q   <= sel_kind;
			out_index_q  <= sel_index;
			out_motion_q <= sel_motion;
			out_last_q   <= (remain == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_index  = out_index_q;
	assign out_motion = out_motion_q;
	assign out_last   = out_last_q;

endmodule
